// ===== sv/assert_macros.svh =====
// Assertion helpers for the K-line receiver. They compile away in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Implication in the same cycle.
`define KRX_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication in the next cycle.
`define KRX_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define KRX_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define KRX_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// ===== sv/krx_pkg.sv =====
`timescale 1ns / 1ps

package krx_pkg;

  // Format byte that announces a frame with one data byte and no length byte.
  localparam logic [7:0] FMT_SINGLE = 8'h81;

  // Register reset values.
  localparam logic [7:0]  ECU_ADDR_RST      = 8'd17;
  localparam logic [7:0]  OWN_ADDR_RST      = 8'd242;
  localparam logic [7:0]  MAX_LEN_RST       = 8'd255;
  localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd1000;

  // Input operation codes.
  typedef enum logic [1:0] {
    OP_BYTE = 2'd0,
    OP_TICK = 2'd1,
    OP_ARM  = 2'd2
  } op_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_ECU_ADDR      = 3'd0,
    REG_OWN_ADDR      = 3'd1,
    REG_MAX_LEN       = 3'd2,
    REG_TIMEOUT_TICKS = 3'd3
  } reg_idx_t;

  typedef enum logic {
    KIND_DATA = 1'b0,
    KIND_DONE = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_CHECKSUM = 2'd1,
    ST_TIMEOUT  = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0]  ecu_addr;
    logic [7:0]  own_addr;
    logic [7:0]  max_len;
    logic [15:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    kind_t      kind;
    logic [7:0] data_byte;
    logic [7:0] data_index;
    status_t    status;
    logic [7:0] byte_count;
  } res_t;

endpackage

// ===== sv/krx_parser.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module krx_parser (
  input  logic           clk,
  input  logic           rst,
  input  logic           step_en,
  input  logic [1:0]     op,
  input  logic [7:0]     rx_byte,
  input  krx_pkg::cfg_t  cfg,
  output krx_pkg::res_t  res
);
  import krx_pkg::*;

  typedef enum logic [4:0] {
    POS_FMT  = 5'b00001,
    POS_TGT  = 5'b00010,
    POS_SRC  = 5'b00100,
    POS_LEN  = 5'b01000,
    POS_DATA = 5'b10000
  } pos_t;

  logic        active, active_next;
  pos_t        pos, pos_next;
  logic        single_fmt, single_fmt_next;
  logic [7:0]  expected_count, expected_count_next;
  logic [7:0]  received_count, received_count_next;
  logic        addressed, addressed_next;
  logic [7:0]  running_sum, running_sum_next;
  logic [15:0] idle_ticks, idle_ticks_next;

  logic [7:0]  sum_add;
  logic [15:0] idle_inc;
  logic        overflow;
  res_t        res_raw;

  assign sum_add  = running_sum + rx_byte;
  assign idle_inc = (idle_ticks != 16'hFFFF) ? idle_ticks + 16'd1 : idle_ticks;
  assign overflow = (received_count >= cfg.max_len);

  // One step of the frame parser: next state and the result it causes.
  always_comb begin
    active_next         = active;
    pos_next            = pos;
    single_fmt_next     = single_fmt;
    expected_count_next = expected_count;
    received_count_next = received_count;
    addressed_next      = addressed;
    running_sum_next    = running_sum;
    idle_ticks_next     = idle_ticks;
    res_raw             = '0;
    res_raw.kind        = KIND_DATA;
    res_raw.status      = ST_OK;

    case (op)
      OP_ARM: begin
        active_next         = 1'b1;
        pos_next            = POS_FMT;
        single_fmt_next     = 1'b0;
        expected_count_next = 8'd0;
        received_count_next = 8'd0;
        addressed_next      = 1'b0;
        running_sum_next    = 8'd0;
        idle_ticks_next     = 16'd0;
      end
      OP_TICK: begin
        if (active) begin
          idle_ticks_next = idle_inc;
          if (idle_inc >= cfg.timeout_ticks) begin
            active_next        = 1'b0;
            res_raw.valid      = 1'b1;
            res_raw.kind       = KIND_DONE;
            res_raw.status     = ST_TIMEOUT;
            res_raw.byte_count = received_count;
          end
        end
      end
      OP_BYTE: begin
        if (active) begin
          idle_ticks_next = 16'd0;
          case (pos)
            POS_FMT: begin
              single_fmt_next     = (rx_byte == FMT_SINGLE);
              expected_count_next = {7'd0, (rx_byte == FMT_SINGLE)};
              received_count_next = 8'd0;
              addressed_next      = 1'b0;
              running_sum_next    = rx_byte;
              pos_next            = POS_TGT;
            end
            POS_TGT: begin
              if (rx_byte == cfg.own_addr) begin
                addressed_next = 1'b1;
              end
              running_sum_next = sum_add;
              pos_next         = POS_SRC;
            end
            POS_SRC: begin
              if (rx_byte == cfg.ecu_addr) begin
                addressed_next = 1'b1;
              end else if (rx_byte == cfg.own_addr) begin
                addressed_next = 1'b0;
              end
              running_sum_next = sum_add;
              pos_next         = POS_DATA;
              pos_next         = POS_LEN;
            end
            POS_LEN: begin
              running_sum_next = sum_add;
              pos_next         = POS_DATA;
              if (single_fmt) begin
                // The lone data byte of a single-byte frame.
                if (overflow) begin
                  active_next        = 1'b0;
                  res_raw.valid      = 1'b1;
                  res_raw.kind       = KIND_DONE;
                  res_raw.status     = ST_OVERFLOW;
                  res_raw.byte_count = received_count;
                end else begin
                  received_count_next = received_count + 8'd1;
                  if (addressed) begin
                    res_raw.valid      = 1'b1;
                    res_raw.data_byte  = rx_byte;
                    res_raw.data_index = received_count;
                  end
                end
              end else begin
                expected_count_next = rx_byte;
              end
            end
            POS_DATA: begin
              if (received_count == expected_count) begin
                // Checksum byte: judge addressed frames, skip the others.
                if (addressed) begin
                  active_next   = 1'b0;
                  res_raw.valid = 1'b1;
                  res_raw.kind  = KIND_DONE;
                  if (running_sum == rx_byte) begin
                    res_raw.status     = ST_OK;
                    res_raw.byte_count = received_count;
                  end else begin
                    res_raw.status     = ST_CHECKSUM;
                    res_raw.byte_count = 8'd0;
                  end
                end else begin
                  pos_next            = POS_FMT;
                  single_fmt_next     = 1'b0;
                  expected_count_next = 8'd0;
                  received_count_next = 8'd0;
                  addressed_next      = 1'b0;
                  running_sum_next    = 8'd0;
                end
              end else begin
                running_sum_next = sum_add;
                if (overflow) begin
                  active_next        = 1'b0;
                  res_raw.valid      = 1'b1;
                  res_raw.kind       = KIND_DONE;
                  res_raw.status     = ST_OVERFLOW;
                  res_raw.byte_count = received_count;
                end else begin
                  received_count_next = received_count + 8'd1;
                  if (addressed) begin
                    res_raw.valid      = 1'b1;
                    res_raw.data_byte  = rx_byte;
                    res_raw.data_index = received_count;
                  end
                end
              end
            end
            default: begin
              pos_next = POS_FMT;
            end
          endcase
        end
      end
      default: begin
        // Unused operation: no effect.
      end
    endcase
  end

  // A result counts only for a step that is actually taken.
  always_comb begin
    res       = res_raw;
    res.valid = res_raw.valid & step_en;
  end

  // Parser state.
  always_ff @(posedge clk) begin
    if (rst) begin
      active         <= 1'b1;
      pos            <= POS_FMT;
      single_fmt     <= 1'b0;
      expected_count <= 8'd0;
      received_count <= 8'd0;
      addressed      <= 1'b0;
      running_sum    <= 8'd0;
      idle_ticks     <= 16'd0;
    end else if (step_en) begin
      active         <= active_next;
      pos            <= pos_next;
      single_fmt     <= single_fmt_next;
      expected_count <= expected_count_next;
      received_count <= received_count_next;
      addressed      <= addressed_next;
      running_sum    <= running_sum_next;
      idle_ticks     <= idle_ticks_next;
    end
  end

  `KRX_ASSERT_NEXT(a_done_stops, clk, rst, res.valid && res.kind == KIND_DONE, !active, "receive did not stop after finish")
  `KRX_ASSERT_IMPL(a_data_addressed, clk, rst, res.valid && res.kind == KIND_DATA, addressed, "data beat from a frame not addressed to this node")
  `KRX_ASSERT_IMPL(a_quiet_when_done, clk, rst, !active, !res.valid, "result produced while finished")
  `KRX_ASSERT_IMPL(a_index_tracks, clk, rst, res.valid && res.kind == KIND_DATA, received_count_next == res.data_index + 8'd1, "data index out of step with count")

endmodule

// ===== sv/kline_response_frame_receiver_core.sv =====
`timescale 1ns / 1ps
// A result passes through the input register and then the result register.
// One input beat per cycle unless a result is held; parser state updates in one pass.
// Input and result registers decouple the sides; in_ready drops only when both are full
// and the result is not taken. Reset is synchronous: the parser listens for a frame,
// counters are cleared and the registers hold their documented defaults.
module kline_response_frame_receiver_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        kind,
  output logic [7:0]  data_byte,
  output logic [7:0]  data_index,
  output logic [1:0]  status,
  output logic [7:0]  byte_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import krx_pkg::*;

  cfg_t       cfg;
  res_t       res;
  logic       s1_valid;
  logic [1:0] s1_op;
  logic [7:0] s1_byte;
  logic       advance;
  logic       step_en;

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid || out_ready;
  assign step_en   = s1_valid && advance;
  assign in_ready  = !s1_valid || advance;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ecu_addr      <= ECU_ADDR_RST;
      cfg.own_addr      <= OWN_ADDR_RST;
      cfg.max_len       <= MAX_LEN_RST;
      cfg.timeout_ticks <= TIMEOUT_TICKS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ECU_ADDR:      cfg.ecu_addr      <= cfg_data[7:0];
        REG_OWN_ADDR:      cfg.own_addr      <= cfg_data[7:0];
        REG_MAX_LEN:       cfg.max_len       <= cfg_data[7:0];
        REG_TIMEOUT_TICKS: cfg.timeout_ticks <= cfg_data;
        default: begin
          // Writes beyond the register list are dropped.
        end
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_op   <= op;
      s1_byte <= rx_byte;
    end
  end

  krx_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step_en (step_en),
    .op      (s1_op),
    .rx_byte (s1_byte),
    .cfg     (cfg),
    .res     (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      kind       <= res.kind;
      data_byte  <= res.data_byte;
      data_index <= res.data_index;
      status     <= res.status;
      byte_count <= res.byte_count;
    end
  end

endmodule
